[rtl/rlsa_pkg.sv]
// Package for the horizontal run-length smear block.
// Holds the run beat type, register indexes and default widths.
// No dependencies.
package rlsa_pkg;

   // Pixel count and run length width
   localparam int LenW = 13;

   // Default largest row
   localparam int DefMaxWidth = 4096;

   // Result queue depth
   localparam int QueueDepth = 4;

   // Register reset values
   localparam logic [LenW-1:0] RowWidthReset = LenW'(640);
   localparam logic [LenW-1:0] GapThresholdReset = LenW'(64);

   // Register index codes
   localparam int CsrIdxW = 2;
   localparam logic [CsrIdxW-1:0] REG_ROW_WIDTH = 2'd0;
   localparam logic [CsrIdxW-1:0] REG_GAP_THRESHOLD = 2'd1;

   // One run beat
   typedef struct packed {
      logic            run_black;
      logic [LenW-1:0] run_length;
      logic            row_end;
      logic            last_of_item;
   } run_type;

endpackage

[rtl/rlsa_horizontal_smear.sv]
// Top level of the horizontal run-length smear: row state, run decisions
// and the configuration registers. Depends on rlsa_pkg and rlsa_run_queue.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   req_pixel_black
//   rsp      out        rsp_valid / rsp_ready   rsp_run_black, rsp_run_length,
//                                               rsp_row_end, rsp_last_of_item
//   csr      in         csr_wr_en               csr_index, csr_wdata
//
// A pixel is decided in the cycle it is accepted; its runs are registered in
// the four-entry run queue and leave on rsp one beat at a time. One pixel per
// cycle while req_ready is high; a pixel that yields two runs drains slower, since the queue has a single-beat output.
// Reset clears row state and the queue and loads the default registers.
// req_ready drops while the queue has room for fewer than two runs.
module rlsa_horizontal_smear
   import rlsa_pkg::*;
#(
   parameter int MAX_WIDTH = DefMaxWidth
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_pixel_black,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_run_black,
   output logic [LenW-1:0]     rsp_run_length,
   output logic                rsp_row_end,
   output logic                rsp_last_of_item,
   input  logic                csr_wr_en,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [LenW-1:0]     csr_wdata
);

   localparam int ColW = $clog2(MAX_WIDTH);
   localparam int SumW = ((ColW > LenW) ? ColW : LenW) + 1;

   logic [LenW-1:0] row_width_ff, gap_threshold_ff;
   logic [ColW-1:0] column_ff, column_in;
   logic [LenW-1:0] pending_white_ff, pending_white_in;
   logic [LenW-1:0] fill_left_ff, fill_left_in;

   logic            accept;
   logic [SumW-1:0] w_eff;
   logic            last;
   logic            fill_ok;
   logic [LenW-1:0] turned;
   logic [LenW-1:0] held_plus;
   logic [1:0]      push_cnt;
   run_type         run0, run1, head;
   logic            room_two;

   assign accept = req_valid && req_ready;
   assign req_ready = room_two;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff     <= RowWidthReset;
         gap_threshold_ff <= GapThresholdReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_ROW_WIDTH:     row_width_ff     <= csr_wdata;
            REG_GAP_THRESHOLD: gap_threshold_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp width and test row position
   always_comb begin
      priority if (row_width_ff == '0) begin
         w_eff = SumW'(1);
      end else if (SumW'(row_width_ff) > SumW'(MAX_WIDTH)) begin
         w_eff = SumW'(MAX_WIDTH);
      end else begin
         w_eff = SumW'(row_width_ff);
      end
      last    = (SumW'(column_ff) + SumW'(1)) >= w_eff;
      fill_ok = (SumW'(column_ff) + SumW'(gap_threshold_ff)) < w_eff;
   end

   // Decide the runs for this pixel
   always_comb begin
      turned    = '0;
      held_plus = pending_white_ff + LenW'(1);
      if (gap_threshold_ff != '0) begin
         turned = (pending_white_ff < gap_threshold_ff - LenW'(1)) ?
                  pending_white_ff : gap_threshold_ff - LenW'(1);
      end

      push_cnt         = 2'd0;
      run0             = '0;
      run1             = '0;
      pending_white_in = pending_white_ff;
      fill_left_in     = fill_left_ff;

      priority if (fill_left_ff != '0) begin
         // forced black fill
         fill_left_in = fill_left_ff - LenW'(1);
         push_cnt     = 2'd1;
         run0         = '{run_black: 1'b1, run_length: LenW'(1), row_end: last,
                          last_of_item: 1'b1};
      end else if (!req_pixel_black) begin
         // hold white, flush at row end
         pending_white_in = held_plus;
         if (last) begin
            push_cnt = 2'd1;
            run0     = '{run_black: 1'b0, run_length: held_plus, row_end: 1'b1,
                         last_of_item: 1'b1};
         end
      end else begin
         // black: split held whites, start fill
         pending_white_in = '0;
         if (pending_white_ff > turned) begin
            push_cnt = 2'd2;
            run0     = '{run_black: 1'b0, run_length: pending_white_ff - turned,
                         row_end: 1'b0, last_of_item: 1'b0};
            run1     = '{run_black: 1'b1, run_length: turned + LenW'(1),
                         row_end: last, last_of_item: 1'b1};
         end else begin
            push_cnt = 2'd1;
            run0     = '{run_black: 1'b1, run_length: turned + LenW'(1),
                         row_end: last, last_of_item: 1'b1};
         end
         if (!last && fill_ok) begin
            fill_left_in = gap_threshold_ff;
         end
      end

      // row end drops all row state
      if (last) begin
         column_in        = '0;
         pending_white_in = '0;
         fill_left_in     = '0;
      end else begin
         column_in = column_ff + ColW'(1);
      end
   end

   // Update row state on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff        <= '0;
         pending_white_ff <= '0;
         fill_left_ff     <= '0;
      end else if (accept) begin
         column_ff        <= column_in;
         pending_white_ff <= pending_white_in;
         fill_left_ff     <= fill_left_in;
      end
   end

   rlsa_run_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (accept ? push_cnt : 2'd0),
      .push_run0 (run0),
      .push_run1 (run1),
      .room_two  (room_two),
      .pop_valid (rsp_valid),
      .pop_ready (rsp_ready),
      .pop_run   (head)
   );

   assign rsp_run_black    = head.run_black;
   assign rsp_run_length   = head.run_length;
   assign rsp_row_end      = head.row_end;
   assign rsp_last_of_item = head.last_of_item;

   // A fill never runs from the start of a row
   a_fill_mid_row : assert property (@(posedge clock) disable iff (reset)
      fill_left_ff != '0 |-> column_ff != '0)
      else $error("fill active at row start");

   // No whites are held during a fill
   a_fill_no_pending : assert property (@(posedge clock) disable iff (reset)
      fill_left_ff != '0 |-> pending_white_ff == '0)
      else $error("white pixels held during fill");

   // Held whites never exceed pixels seen in the row
   a_pending_bound : assert property (@(posedge clock) disable iff (reset)
      SumW'(pending_white_ff) <= SumW'(column_ff))
      else $error("held white count beyond column");

endmodule

[rtl/rlsa_run_queue.sv]
// Small result queue for the smear block: takes up to two runs a cycle,
// gives one run beat a cycle while pop_ready is high. Depends on rlsa_pkg.
module rlsa_run_queue
   import rlsa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [1:0]   push_cnt,
   input  run_type      push_run0,
   input  run_type      push_run1,
   output logic         room_two,
   output logic         pop_valid,
   input  logic         pop_ready,
   output run_type      pop_run
);

   localparam int PtrW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);

   run_type               mem_ff [QueueDepth];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]       count_ff, count_in;
   logic                  pop;

   assign pop       = pop_valid && pop_ready;
   assign pop_valid = (count_ff != '0);
   assign pop_run   = mem_ff[rd_ptr_ff];
   assign room_two  = (count_ff <= CntW'(QueueDepth - 2));

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrW'(push_cnt);
      rd_ptr_in = rd_ptr_ff + PtrW'(pop);
      count_in  = count_ff + CntW'(push_cnt) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed runs
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_run0;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_ptr_ff + PtrW'(1)] <= push_run1;
      end
   end

   // Never overfill
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push_cnt != 2'd0 |-> CntW'(count_ff - CntW'(pop)) <= CntW'(QueueDepth) - CntW'(push_cnt))
      else $error("run queue overflow");

   // Count tracks pushes and pops
   a_count_step : assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> count_ff == $past(count_ff) + CntW'($past(push_cnt)) - CntW'($past(pop)))
      else $error("run queue count mismatch");

endmodule

[test/rlsa_horizontal_smear_tb.sv]
// Self-checking bench for rlsa_horizontal_smear: drives pixel beats, predicts
// the smeared runs and compares every run beat field by field.
// Depends on rlsa_pkg and the rlsa_horizontal_smear RTL.
module rlsa_horizontal_smear_tb
   import rlsa_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Indexes that map to no register; writes to them must be ignored
   localparam logic [CsrIdxW-1:0] REG_SPARE_A = 2'd2;
   localparam logic [CsrIdxW-1:0] REG_SPARE_B = 2'd3;

   // Cycles to let pass after the last run before touching registers
   localparam int SettleCycles = 8;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   logic            req_pixel_black = 1'b0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   logic            rsp_run_black;
   logic [LenW-1:0] rsp_run_length;
   logic            rsp_row_end;
   logic            rsp_last_of_item;
   logic            csr_wr_en = 1'b0;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [LenW-1:0] csr_wdata = '0;

   rlsa_horizontal_smear dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_black  (req_pixel_black),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_run_black    (rsp_run_black),
      .rsp_run_length   (rsp_run_length),
      .rsp_row_end      (rsp_row_end),
      .rsp_last_of_item (rsp_last_of_item),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Pixels waiting to be driven and runs waiting to be seen
   logic    pixel_q[$];
   run_type expected_runs[$];
   int      pixels_queued = 0;
   int      pixels_taken = 0;
   int      mismatches = 0;
   int      send_idle_pct = 0;
   int      rsp_stall_pct = 0;
   bit      req_taken = 1'b0;

   // Predicted row state and register copies
   logic [11:0]     row_col;
   logic [LenW-1:0] held_white;
   logic [LenW-1:0] fill_count;
   logic [LenW-1:0] cfg_width;
   logic [LenW-1:0] cfg_gap;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   function automatic void add_run(input logic black, input int len, input logic at_end);
      run_type r;
      r.run_black = black;
      r.run_length = LenW'(len);
      r.row_end = at_end;
      r.last_of_item = 1'b0;
      expected_runs.push_back(r);
   endfunction

   // Advance the row by one pixel and queue the runs it releases
   function automatic void smear_pixel(input logic pix);
      int  w;
      int  t;
      int  held;
      int  turned;
      int  prior_runs;
      bit  at_end;
      w = int'(cfg_width);
      if (w == 0) w = 1;
      if (w > DefMaxWidth) w = DefMaxWidth;
      t = int'(cfg_gap);
      at_end = (int'(row_col) + 1) >= w;
      prior_runs = expected_runs.size();
      if (fill_count != 0) begin
         fill_count = fill_count - 1'b1;
         add_run(1'b1, 1, at_end);
      end else if (!pix) begin
         held_white = held_white + 1'b1;
         if (at_end) add_run(1'b0, int'(held_white), 1'b1);
      end else begin
         held = int'(held_white);
         turned = 0;
         if (t > 0) turned = (held < t - 1) ? held : t - 1;
         if (held > turned) add_run(1'b0, held - turned, 1'b0);
         add_run(1'b1, turned + 1, at_end);
         held_white = '0;
         if (!at_end && int'(row_col) + t < w) fill_count = cfg_gap;
      end
      if (at_end) begin
         row_col = '0;
         held_white = '0;
         fill_count = '0;
      end else begin
         row_col = row_col + 1'b1;
      end
      if (expected_runs.size() > prior_runs)
         expected_runs[expected_runs.size() - 1].last_of_item = 1'b1;
   endfunction

   // Monitor: track accepted pixels, register writes and run beats
   always @(posedge clock) begin
      run_type want;
      if (reset) begin
         row_col = '0;
         held_white = '0;
         fill_count = '0;
         cfg_width = RowWidthReset;
         cfg_gap = GapThresholdReset;
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            smear_pixel(req_pixel_black);
            pixels_taken++;
         end
         if (csr_wr_en) begin
            if (csr_index == REG_ROW_WIDTH) cfg_width = csr_wdata;
            else if (csr_index == REG_GAP_THRESHOLD) cfg_gap = csr_wdata;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_runs.size() == 0) begin
               report_mismatch($sformatf("run beat with nothing expected: black %0b len %0d",
                                         rsp_run_black, rsp_run_length));
            end else begin
               want = expected_runs.pop_front();
               if (rsp_run_black !== want.run_black)
                  report_mismatch($sformatf("run_black %0b, expected %0b",
                                            rsp_run_black, want.run_black));
               if (rsp_run_length !== want.run_length)
                  report_mismatch($sformatf("run_length %0d, expected %0d",
                                            rsp_run_length, want.run_length));
               if (rsp_row_end !== want.row_end)
                  report_mismatch($sformatf("row_end %0b, expected %0b",
                                            rsp_row_end, want.row_end));
               if (rsp_last_of_item !== want.last_of_item)
                  report_mismatch($sformatf("last_of_item %0b, expected %0b",
                                            rsp_last_of_item, want.last_of_item));
            end
         end
      end
   end

   // Driver: hold a beat until taken, then maybe present the next one
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_pixel_black <= pixel_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic void queue_pixel(input logic pix);
      pixel_q.push_back(pix);
      pixels_queued++;
   endfunction

   // Queue n pixels, first one from the MSB
   function automatic void queue_bits(input logic [31:0] bits, input int n);
      for (int i = n - 1; i >= 0; i--) queue_pixel(bits[i]);
   endfunction

   task automatic wait_drained();
      while (pixels_taken != pixels_queued || expected_runs.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input int value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= LenW'(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_config(input int width, input int gap);
      wait_drained();
      write_reg(REG_ROW_WIDTH, width);
      write_reg(REG_GAP_THRESHOLD, gap);
      @(posedge clock);
   endtask

   // Mostly white gaps closed by short black runs, with some loose noise
   task automatic queue_random(input int count, input int gap);
      int done;
      int white_len;
      int black_len;
      done = 0;
      while (done < count) begin
         if ($urandom_range(99) < 20) begin
            queue_pixel(1'($urandom_range(1)));
            done++;
         end else begin
            white_len = $urandom_range(0, 2 * gap + 2);
            black_len = $urandom_range(1, 3);
            repeat (white_len) queue_pixel(1'b0);
            repeat (black_len) queue_pixel(1'b1);
            done += white_len + black_len;
         end
      end
   endtask

   task automatic run_phase(input int width, input int gap, input int idle, input int stall,
                            input int count);
      set_config(width, gap);
      send_idle_pct = idle;
      rsp_stall_pct = stall;
      queue_random(count, (gap > 40) ? 40 : gap);
   endtask

   initial begin
      int w;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset register values: black opens a long fill
      queue_bits(32'b1001, 4);

      // Width zero acts as one, threshold zero turns nothing; spare indexes ignored
      set_config(0, 0);
      write_reg(REG_SPARE_A, 5);
      write_reg(REG_SPARE_B, 7);
      @(posedge clock);
      queue_bits(32'b0110, 4);

      // Short rows: partial turn with white leftover, fill then black at row end
      set_config(6, 3);
      queue_bits(32'b000100, 6);
      queue_bits(32'b100001, 6);

      // Oversized width and threshold clamp / exceed
      set_config(8191, 8191);
      queue_bits(32'b01, 2);

      // Random phases over the idling patterns
      run_phase(16, 4, 0, 0, 60);
      w = $urandom_range(2, 40);
      run_phase(w, $urandom_range(0, w), 86, 0, 60);
      run_phase(12, 0, 0, 86, 60);
      run_phase(20, 20, 34, 34, 60);
      run_phase(1, 3, 86, 86, 40);
      run_phase($urandom_range(1, 64), $urandom_range(0, 8191), 0, 0, 60);

      run_phase(24, 6, 34, 34, 80);
      wait_drained();

      if (mismatches == 0) begin
         $display("rlsa_horizontal_smear test passed");
      end else begin
         $display("rlsa_horizontal_smear test failed");
      end
      $finish;
   end

   // Hard stop well past the slowest correct run
   initial begin
      #10_000_000;
      $display("rlsa_horizontal_smear test failed");
      $finish;
   end

endmodule
